[design/iems_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package iems_pkg;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [14:0] start_address;
      logic [15:0] byte_count;
      logic [7:0]  write_byte;
      logic        sda_sample;
   } req_type_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic [7:0] read_data;
      logic       read_valid;
      logic       read_last;
      logic       byte_taken;
      logic       done_res;
      logic [1:0] status;
   } rsp_type_type;

   typedef struct packed {
      logic [7:0]  device_address_byte;
      logic [8:0]  page_size;
      logic [9:0]  poll_limit;
      logic [11:0] write_recovery_ticks;
   } cfg_type;

   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;
   localparam logic [1:0] REQ_PROBE = 2'd3;

   localparam logic [1:0] CSR_DEV  = 2'd0;
   localparam logic [1:0] CSR_PAGE = 2'd1;
   localparam logic [1:0] CSR_POLL = 2'd2;
   localparam logic [1:0] CSR_REC  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOACK   = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;

endpackage
`default_nettype wire

[design/iems_csr.sv]
`timescale 1ns / 1ps
`default_nettype none
module iems_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_write_enable,
   input  wire logic [1:0]      csr_index,
   input  wire logic [11:0]     csr_write_data,
   output iems_pkg::cfg_type    cfg
);
   import iems_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address_byte  <= 8'd160;
         cfg_ff.page_size            <= 9'd64;
         cfg_ff.poll_limit           <= 10'd1000;
         cfg_ff.write_recovery_ticks <= 12'd1250;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEV:  cfg_ff.device_address_byte  <= csr_write_data[7:0];
            CSR_PAGE: cfg_ff.page_size            <= csr_write_data[8:0];
            CSR_POLL: cfg_ff.poll_limit           <= csr_write_data[9:0];
            CSR_REC:  cfg_ff.write_recovery_ticks <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

[design/iems_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
module iems_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  iems_pkg::req_type_type    req,
   input  iems_pkg::cfg_type         cfg,
   output iems_pkg::rsp_type_type    rsp
);
   import iems_pkg::*;

   typedef enum logic [4:0] {
      PH_IDLE, PH_P_STOP1, PH_P_START, PH_P_DEV, PH_P_ACK, PH_P_STOP2,
      PH_R_START1, PH_R_DEVW, PH_R_ACK1, PH_R_AH, PH_R_ACK2, PH_R_AL,
      PH_R_ACK3, PH_R_START2, PH_R_DEVR, PH_R_ACK4, PH_R_DATA, PH_R_ACKOUT,
      PH_W_STOP_PAGE, PH_W_START, PH_W_DEV, PH_W_POLLACK, PH_W_AH,
      PH_W_AACK1, PH_W_AL, PH_W_AACK2, PH_W_DATA, PH_W_DACK, PH_W_STOP_END,
      PH_W_RECOVER, PH_STOP_OK, PH_STOP_FAIL
   } phase_type;

   phase_type   phase_ff, phase_in, ph;
   logic [1:0]  step_ff, step_in, ts;
   logic [2:0]  bit_ff, bit_in, bi;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] left_ff, left_in;
   logic [9:0]  poll_ff, poll_in;
   logic [11:0] wait_ff, wait_in;
   logic [1:0]  lines_ff, lines_in;
   logic        scl, sda, stop_seen, fin, busy, valid, last, taken, done;
   logic [1:0]  status;
   logic [7:0]  data, sb, sent_bit_src;
   logic [9:0]  poll_inc;
   logic [8:0]  page_mask;
   logic [15:0] addr_inc;

   always_comb begin
      ph = phase_ff; ts = step_ff; bi = bit_ff; sb = shift_ff;
      addr_in = addr_ff; left_in = left_ff; poll_in = poll_ff; wait_in = wait_ff;
      busy = 1'b1; valid = 1'b0; data = 8'd0; last = 1'b0; taken = 1'b0;
      done = 1'b0; status = ST_OK; stop_seen = 1'b0; fin = 1'b0;
      scl = lines_ff[1]; sda = lines_ff[0];
      sent_bit_src = 8'd0; poll_inc = 10'd0;
      page_mask = cfg.page_size - 9'd1;
      addr_inc = addr_ff + 16'd1;
      if (phase_ff == PH_IDLE) begin
         if (req.req_type == REQ_TICK) begin
            busy = 1'b0;
         end else begin
            addr_in = {1'b0, req.start_address};
            left_in = req.byte_count;
            poll_in = 10'd0; wait_in = 12'd0; ts = 2'd0; bi = 3'd0; sb = 8'd0;
            unique case (req.req_type)
               REQ_PROBE: ph = PH_P_STOP1;
               REQ_READ:  ph = PH_R_START1;
               default:   ph = (req.byte_count != 16'd0) ? PH_W_STOP_PAGE
                                                          : PH_W_STOP_END;
            endcase
         end
      end
      phase_in = ph; step_in = ts; bit_in = bi; shift_in = sb;
      // shared primitive completions evaluated per phase
      unique case (ph)
         PH_P_STOP1, PH_W_STOP_PAGE, PH_STOP_OK, PH_STOP_FAIL, PH_P_STOP2,
         PH_W_STOP_END: begin
            scl = 1'b1; sda = 1'b0; stop_seen = 1'b1;
         end
         PH_P_START, PH_R_START1, PH_R_START2, PH_W_START: begin
            scl = (ts < 2'd2); sda = (ts == 2'd0);
            fin = (ts >= 2'd2);
            step_in = fin ? 2'd0 : ts + 2'd1;
         end
         PH_P_DEV, PH_R_DEVW, PH_R_AH, PH_R_AL, PH_R_DEVR, PH_W_DEV, PH_W_AH,
         PH_W_AL, PH_W_DATA: begin
            sent_bit_src = sb;
            if (ph == PH_W_DATA && bi == 3'd0 && ts == 2'd0) begin
               sent_bit_src = req.write_byte; taken = 1'b1;
            end
            shift_in = sent_bit_src;
            if (ts == 2'd0) begin
               scl = 1'b0; sda = sent_bit_src[7]; step_in = 2'd1;
            end else if (ts == 2'd1) begin
               scl = 1'b1; sda = sent_bit_src[7]; step_in = 2'd2;
            end else begin
               scl = 1'b0; sda = (bi == 3'd7) ? 1'b1 : sent_bit_src[7];
               shift_in = {sent_bit_src[6:0], 1'b0}; step_in = 2'd0;
               fin = (bi == 3'd7);
               bit_in = fin ? 3'd0 : bi + 3'd1;
            end
         end
         PH_P_ACK, PH_R_ACK1, PH_R_ACK2, PH_R_ACK3, PH_R_ACK4, PH_W_POLLACK,
         PH_W_AACK1, PH_W_AACK2, PH_W_DACK: begin
            if (ts == 2'd1) shift_in = {7'd0, req.sda_sample};
            scl = (ts == 2'd1); sda = 1'b1;
            fin = (ts >= 2'd2);
            step_in = fin ? 2'd0 : ts + 2'd1;
         end
         PH_R_DATA: begin
            if (ts == 2'd0) begin
               scl = 1'b1; sda = 1'b1;
               shift_in = {sb[6:0], req.sda_sample}; step_in = 2'd1;
               if (bi == 3'd7) begin
                  valid = 1'b1; data = {sb[6:0], req.sda_sample};
                  last = (left_ff == 16'd1);
               end
            end else begin
               scl = 1'b0; sda = 1'b1; step_in = 2'd0;
               fin = (bi == 3'd7);
               bit_in = fin ? 3'd0 : bi + 3'd1;
            end
         end
         PH_R_ACKOUT: begin
            scl = (ts == 2'd1); sda = (left_ff <= 16'd1);
            fin = (ts >= 2'd2);
            step_in = fin ? 2'd0 : ts + 2'd1;
         end
         default: ;
      endcase
      // phase transitions; enter() clears step and bit
      unique case (ph)
         PH_P_STOP1: begin phase_in = PH_P_START; step_in = 2'd0; bit_in = 3'd0;
            shift_in = 8'd0; end
         PH_P_START, PH_R_START1, PH_R_START2, PH_W_START: if (fin) begin
            bit_in = 3'd0;
            phase_in = (ph == PH_P_START) ? PH_P_DEV :
                       (ph == PH_R_START1) ? PH_R_DEVW :
                       (ph == PH_R_START2) ? PH_R_DEVR : PH_W_DEV;
            shift_in = (ph == PH_R_START2) ? (cfg.device_address_byte | 8'd1)
                                           : cfg.device_address_byte;
         end
         PH_P_DEV, PH_R_DEVW, PH_R_AH, PH_R_AL, PH_R_DEVR, PH_W_DEV, PH_W_AH,
         PH_W_AL, PH_W_DATA: if (fin) begin
            shift_in = 8'd0;
            phase_in = (ph == PH_P_DEV) ? PH_P_ACK :
                       (ph == PH_R_DEVW) ? PH_R_ACK1 :
                       (ph == PH_R_AH) ? PH_R_ACK2 :
                       (ph == PH_R_AL) ? PH_R_ACK3 :
                       (ph == PH_R_DEVR) ? PH_R_ACK4 :
                       (ph == PH_W_DEV) ? PH_W_POLLACK :
                       (ph == PH_W_AH) ? PH_W_AACK1 :
                       (ph == PH_W_AL) ? PH_W_AACK2 : PH_W_DACK;
         end
         PH_P_ACK: if (fin) phase_in = PH_P_STOP2;
         PH_P_STOP2: begin
            step_in = 2'd0; bit_in = 3'd0;
            if (sb[0]) begin phase_in = PH_STOP_FAIL; shift_in = 8'd1; end
            else begin phase_in = PH_IDLE; done = 1'b1; status = ST_OK; end
         end
         PH_R_ACK1, PH_R_ACK2, PH_R_ACK3, PH_R_ACK4, PH_W_AACK1, PH_W_AACK2:
         if (fin) begin
            if (shift_in[0]) begin phase_in = PH_STOP_FAIL; shift_in = 8'd1; end
            else begin
               unique case (ph)
                  PH_R_ACK1: begin phase_in = PH_R_AH; shift_in = {1'b0, addr_ff[14:8]}; end
                  PH_R_ACK2: begin phase_in = PH_R_AL; shift_in = addr_ff[7:0]; end
                  PH_R_ACK3: begin phase_in = PH_R_START2; shift_in = 8'd0; end
                  PH_R_ACK4: begin shift_in = 8'd0;
                     phase_in = (left_ff != 16'd0) ? PH_R_DATA : PH_STOP_OK; end
                  PH_W_AACK1: begin phase_in = PH_W_AL; shift_in = addr_ff[7:0]; end
                  default: begin phase_in = PH_W_DATA; shift_in = 8'd0; end
               endcase
            end
         end
         PH_R_DATA: if (fin) phase_in = PH_R_ACKOUT;
         PH_R_ACKOUT: if (fin) begin
            shift_in = 8'd0;
            if (left_ff != 16'd0) left_in = left_ff - 16'd1;
            phase_in = (left_ff <= 16'd1) ? PH_STOP_OK : PH_R_DATA;
         end
         PH_W_STOP_PAGE: begin
            poll_in = 10'd0; phase_in = PH_W_START;
            step_in = 2'd0; bit_in = 3'd0; shift_in = 8'd0;
         end
         PH_W_POLLACK: if (fin) begin
            if (!shift_in[0]) begin
               phase_in = PH_W_AH; shift_in = {1'b0, addr_ff[14:8]};
            end else begin
               poll_inc = poll_ff + 10'd1; poll_in = poll_inc; shift_in = 8'd0;
               if (poll_inc >= cfg.poll_limit) begin
                  phase_in = PH_STOP_FAIL; shift_in = 8'd2;
               end else phase_in = PH_W_START;
            end
         end
         PH_W_DACK: if (fin) begin
            if (shift_in[0]) begin phase_in = PH_STOP_FAIL; shift_in = 8'd1; end
            else begin
               shift_in = 8'd0; addr_in = addr_inc;
               if (left_ff != 16'd0) left_in = left_ff - 16'd1;
               if (left_ff <= 16'd1) phase_in = PH_W_STOP_END;
               else if ((addr_inc[8:0] & page_mask) == 9'd0) phase_in = PH_W_STOP_PAGE;
               else phase_in = PH_W_DATA;
            end
         end
         PH_W_STOP_END: begin
            step_in = 2'd0; bit_in = 3'd0;
            if (cfg.write_recovery_ticks == 12'd0) begin
               phase_in = PH_IDLE; done = 1'b1;
            end else begin
               wait_in = cfg.write_recovery_ticks; phase_in = PH_W_RECOVER;
               shift_in = 8'd0;
            end
         end
         PH_W_RECOVER: begin
            if (wait_ff != 12'd0) wait_in = wait_ff - 12'd1;
            if (wait_ff <= 12'd1) begin phase_in = PH_IDLE; done = 1'b1; end
         end
         PH_STOP_OK: begin phase_in = PH_IDLE; done = 1'b1; step_in = 2'd0;
            bit_in = 3'd0; end
         PH_STOP_FAIL: begin phase_in = PH_IDLE; done = 1'b1; step_in = 2'd0;
            bit_in = 3'd0; status = sb[1:0]; end
         default: ;
      endcase
      lines_in = stop_seen ? 2'b11 : {scl, sda};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; step_ff <= 2'd0; bit_ff <= 3'd0; shift_ff <= 8'd0;
         addr_ff <= 16'd0; left_ff <= 16'd0; poll_ff <= 10'd0; wait_ff <= 12'd0;
         lines_ff <= 2'b11;
      end else if (step) begin
         phase_ff <= phase_in; step_ff <= step_in; bit_ff <= bit_in;
         shift_ff <= shift_in; addr_ff <= addr_in; left_ff <= left_in;
         poll_ff <= poll_in; wait_ff <= wait_in; lines_ff <= lines_in;
      end
   end

   always_comb begin
      rsp.scl_level = scl; rsp.sda_level = sda; rsp.busy_res = busy;
      rsp.read_data = data; rsp.read_valid = valid; rsp.read_last = last;
      rsp.byte_taken = taken; rsp.done_res = done; rsp.status = status;
   end
endmodule
`default_nettype wire

[design/i2c_eeprom_master_sequencer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Bit-banged i2c master for a two-byte-address serial eeprom. Each accepted item is one
// bus tick; its result item gives the scl and sda levels for that tick plus read data,
// write byte consumption, busy, done and status. One item per cycle is sustained: the
// sequencer state advances when an item is taken, and the result sits in an output
// register that releases the input side whenever it is empty or being drained. The result
// is valid in the cycle after the input is accepted.
module i2c_eeprom_master_sequencer_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  iems_pkg::req_type_type    req_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output iems_pkg::rsp_type_type    rsp_data,
   input  wire logic                 csr_write_enable,
   input  wire logic [1:0]           csr_index,
   input  wire logic [11:0]          csr_write_data
);
   import iems_pkg::*;

   cfg_type      cfg;
   rsp_type_type rsp_next;
   rsp_type_type rsp_ff;
   logic         valid_ff;
   logic         take;

   // input side flows when the output register is free or emptying
   assign req_ready = !valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   iems_csr u_csr (
      .clock, .reset, .csr_write_enable, .csr_index, .csr_write_data, .cfg
   );

   iems_seq u_seq (
      .clock, .reset, .step(take), .req(req_data), .cfg, .rsp(rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
      if (take) rsp_ff <= rsp_next;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

[design/iems_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module iems_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input iems_pkg::rsp_type_type    rsp_data
);
   import iems_pkg::*;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   a_one_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item produced no result");

   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.done_res |-> rsp_data.status == ST_OK)
      else $error("status without done");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.done_res || rsp_data.read_valid || rsp_data.byte_taken)
      |-> rsp_data.busy_res)
      else $error("event outside transaction");
endmodule

bind i2c_eeprom_master_sequencer_unit iems_checker u_iems_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);
`default_nettype wire
